// File: rtl/core/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared sizes, codes and controller/datapath bundles for the 4x4 Q16.16
// matrix multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;
    localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int FLD_W     = 2;
    localparam int VAL_W     = 32;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam int SH_W      = ACC_W - FRAC_BITS;

    localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_WR_A = 2'd0,
        CMD_WR_B = 2'd1,
        CMD_MUL  = 2'd2,
        CMD_RD   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT,
        S_RD
    } t_state;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_start;
        logic             fetch;
        logic             capture;
        logic             emit_mul;
        logic             emit_rd;
        logic             last;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] k;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic acc_done;
    } t_dp_sts;

    function automatic logic [CELL_W-1:0] cell_addr(input int unsigned r,
                                                    input int unsigned c);
        return CELL_W'(r * DIM + c);
    endfunction

endpackage

// File: rtl/core/mm4_in_if.sv
// ----------------------------------------------------------------------------
// mm4_in_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface mm4_in_if import mm4_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [FLD_W-1:0]        cmd;
    logic [FLD_W-1:0]        row;
    logic [FLD_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output cmd, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input cmd, input row, input col, input value,
                    output ready);

endinterface

// File: rtl/core/mm4_out_if.sv
// ----------------------------------------------------------------------------
// mm4_out_if
// Result channel: valid/ready handshake carrying one matrix element item.
// ----------------------------------------------------------------------------
interface mm4_out_if import mm4_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [FLD_W-1:0]        out_row;
    logic [FLD_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    saturated;
    logic                    last;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output saturated, output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input saturated, input last, output ready);

endinterface

// File: rtl/core/mm4_ctrl.sv
// ----------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: accepts command items, walks row/column/term counters for a
// multiply and tells the datapath when to fetch, accumulate and emit.
// ----------------------------------------------------------------------------
module mm4_ctrl import mm4_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [FLD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    output t_dp_cmd          o_cmd,
    input  t_dp_sts          i_sts
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_r, n_r;
    logic [IDX_W-1:0] r_c, n_c;
    logic [IDX_W-1:0] r_k, n_k;
    logic             accept;
    t_cmd             item_cmd;
    logic             k_end;
    logic             row_end;
    logic             mat_end;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign item_cmd = t_cmd'(i_in_cmd);
    assign k_end    = (r_k == IDX_W'(DIM - 1));
    assign row_end  = (r_c == IDX_W'(DIM - 1));
    assign mat_end  = (r_r == IDX_W'(DIM - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_r     <= n_r;
            r_c     <= n_c;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_c     = r_c;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (item_cmd)
                        CMD_MUL: begin
                            n_state = S_ISSUE;
                            n_r     = '0;
                            n_c     = '0;
                            n_k     = '0;
                        end
                        CMD_RD:   n_state = S_RD;
                        CMD_WR_A: n_state = S_IDLE;
                        CMD_WR_B: n_state = S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ISSUE: begin
                if (k_end) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_sts.acc_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    if (row_end) begin
                        n_c = '0;
                        if (mat_end) begin
                            n_state = S_IDLE;
                        end else begin
                            n_r     = r_r + 1'b1;
                            n_state = S_ISSUE;
                        end
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_RD: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.r    = r_r;
        o_cmd.c    = r_c;
        o_cmd.k    = r_k;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.wr_a     = accept && (item_cmd == CMD_WR_A);
                o_cmd.wr_b     = accept && (item_cmd == CMD_WR_B);
                o_cmd.rd_start = accept && (item_cmd == CMD_RD);
            end
            S_ISSUE: begin
                o_cmd.fetch   = 1'b1;
                o_cmd.capture = (r_c == '0);
            end
            S_EMIT: begin
                o_cmd.emit_mul = !i_sts.out_busy;
                o_cmd.last     = row_end && mat_end;
            end
            S_RD: begin
                o_cmd.emit_rd = !i_sts.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.acc_done |-> r_state == S_DRAIN)
        else $error("accumulator finished outside drain");

    a_issue_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) && k_end |=> r_state == S_DRAIN)
        else $error("last term issued but no drain");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_mul || o_cmd.emit_rd |-> !i_sts.out_busy)
        else $error("emit into occupied output register");

endmodule

// File: rtl/core/mm4_datapath.sv
// ----------------------------------------------------------------------------
// mm4_datapath
// Matrix stores, operand fetch, 32x32 multiplier, exact accumulator,
// shift-and-saturate and the output register.
// ----------------------------------------------------------------------------
module mm4_datapath import mm4_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic [FLD_W-1:0]        i_row,
    input  logic [FLD_W-1:0]        i_col,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [FLD_W-1:0]        o_out_row,
    output logic [FLD_W-1:0]        o_out_col,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic                    o_out_saturated,
    output logic                    o_out_last
);

    logic [VAL_W-1:0]        r_a_mem [CELLS];
    logic [VAL_W-1:0]        r_b_mem [CELLS];
    logic [CELLS-1:0]        r_a_vld;
    logic [CELLS-1:0]        r_b_vld;
    logic [VAL_W-1:0]        r_oldrow [DIM];
    logic signed [VAL_W-1:0] r_a_op;
    logic signed [VAL_W-1:0] r_b_op;
    logic                    r_f_vld, r_f_first, r_f_last;
    logic                    r_m_vld, r_m_first, r_m_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_acc_done;
    logic [FLD_W-1:0]        r_rd_row, r_rd_col;
    logic                    r_rd_inside;
    logic                    r_out_valid;
    logic [FLD_W-1:0]        r_out_row, r_out_col;
    logic [VAL_W-1:0]        r_out_value;
    logic                    r_out_sat, r_out_last;

    logic                    item_inside;
    logic [CELL_W-1:0]       item_addr, mul_addr, a_rd_addr, b_rd_addr;
    logic [ACC_W-1:0]        acc_base;
    logic [SH_W-VAL_W:0]     sat_top;
    logic                    sat_hit;
    logic [VAL_W-1:0]        sat_value;

    always_comb begin
        item_inside = (int'(i_row) < DIM) && (int'(i_col) < DIM);
        item_addr   = cell_addr(int'(i_row), int'(i_col));
        mul_addr    = cell_addr(int'(i_cmd.r), int'(i_cmd.c));
        a_rd_addr   = i_cmd.fetch ? cell_addr(int'(i_cmd.r), int'(i_cmd.k)) : item_addr;
        b_rd_addr   = cell_addr(int'(i_cmd.k), int'(i_cmd.c));
    end

    always_comb begin
        sat_top   = r_acc[ACC_W-1:VAL_W-1+FRAC_BITS];
        sat_hit   = !((&sat_top) || !(|sat_top));
        sat_value = sat_hit ? (r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX)
                            : r_acc[VAL_W-1+FRAC_BITS:FRAC_BITS];
        acc_base  = r_m_first ? '0 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && item_inside) begin
            r_a_mem[item_addr] <= i_value;
        end else if (i_cmd.emit_mul) begin
            r_a_mem[mul_addr] <= sat_value;
        end
        if (i_cmd.wr_b && item_inside) begin
            r_b_mem[item_addr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
        end else begin
            if (i_cmd.wr_a && item_inside) begin
                r_a_vld[item_addr] <= 1'b1;
            end else if (i_cmd.emit_mul) begin
                r_a_vld[mul_addr] <= 1'b1;
            end
            if (i_cmd.wr_b && item_inside) begin
                r_b_vld[item_addr] <= 1'b1;
            end
        end
    end

    // Old row of A is kept for columns after the first; new elements overwrite it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch || i_cmd.rd_start) begin
            if (!i_cmd.fetch || i_cmd.capture) begin
                r_a_op <= r_a_vld[a_rd_addr] ? r_a_mem[a_rd_addr] : '0;
            end else begin
                r_a_op <= r_oldrow[i_cmd.k];
            end
        end
        if (i_cmd.fetch && i_cmd.capture) begin
            r_oldrow[i_cmd.k] <= r_a_vld[a_rd_addr] ? r_a_mem[a_rd_addr] : '0;
        end
        if (i_cmd.fetch) begin
            r_b_op    <= r_b_vld[b_rd_addr] ? r_b_mem[b_rd_addr] : '0;
            r_f_first <= (i_cmd.k == '0);
            r_f_last  <= (i_cmd.k == IDX_W'(DIM - 1));
        end
        if (i_cmd.rd_start) begin
            r_rd_row    <= i_row;
            r_rd_col    <= i_col;
            r_rd_inside <= item_inside;
        end
        if (r_f_vld) begin
            r_prod    <= r_a_op * r_b_op;
            r_m_first <= r_f_first;
            r_m_last  <= r_f_last;
        end
        if (r_m_vld) begin
            r_acc <= acc_base + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld    <= 1'b0;
            r_m_vld    <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_f_vld    <= i_cmd.fetch;
            r_m_vld    <= r_f_vld;
            r_acc_done <= r_m_vld && r_m_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_mul || i_cmd.emit_rd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_mul) begin
            r_out_row   <= FLD_W'(i_cmd.r);
            r_out_col   <= FLD_W'(i_cmd.c);
            r_out_value <= sat_value;
            r_out_sat   <= sat_hit;
            r_out_last  <= i_cmd.last;
        end else if (i_cmd.emit_rd) begin
            r_out_row   <= r_rd_row;
            r_out_col   <= r_rd_col;
            r_out_value <= r_rd_inside ? r_a_op : '0;
            r_out_sat   <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_sts.acc_done  = r_acc_done;
    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_out_value     = r_out_value;
    assign o_out_saturated = r_out_sat;
    assign o_out_last      = r_out_last;

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sat |-> r_out_value == SAT_MAX || r_out_value == SAT_MIN)
        else $error("saturated element not at a range limit");

    a_pipe_empty_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_done |-> !r_f_vld && !r_m_vld)
        else $error("terms still in flight when sum reported complete");

endmodule

// File: rtl/core/matrix4_multiply_accumulate_unit.sv
// ----------------------------------------------------------------------------
// matrix4_multiply_accumulate_unit
// 4x4 signed Q16.16 matrix multiply-accumulate: A <= A * B, element writes
// and element reads of A.
// ----------------------------------------------------------------------------
// Commands are taken one at a time. A write of A or B updates the store and
// leaves the sequencer idle. A read of A waits for the output register to
// free up and returns one item. A multiply runs every element through a
// single shared 32x32 multiplier, one product term per cycle: each element
// issues DIM terms, which pass through fetch, multiply and accumulate, and
// is then emitted once the output register is free. The sixteen new
// elements leave in row-major order; the last one carries last = 1. Sums are
// exact, floored by 16 fraction bits and clipped to 32 bits, with saturated
// set on clipped elements. Both matrices read as zero after reset.
// ----------------------------------------------------------------------------
module matrix4_multiply_accumulate_unit import mm4_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm4_in_if.sink    i_in,
    mm4_out_if.source o_out
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    mm4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    assign i_in.ready = in_ready;

    mm4_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_row           (i_in.row),
        .i_col           (i_in.col),
        .i_value         (i_in.value),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_out_row       (o_out.out_row),
        .o_out_col       (o_out.out_col),
        .o_out_value     (o_out.out_value),
        .o_out_saturated (o_out.saturated),
        .o_out_last      (o_out.last)
    );

endmodule

// File: tb/mm4_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mm4_result_checker
// Watches the command and result channels of the 4x4 Q16.16 matrix unit,
// keeps its own copy of both matrices, predicts every emitted element and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mm4_result_checker import mm4_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mm4_in_if    i_cmd_ch,
    mm4_out_if   i_res_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [FLD_W-1:0] row;
        logic [FLD_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             sat;
        logic             last;
    } t_elem;

    localparam logic signed [127:0] SUM_MAX = 128'sd2147483647;
    localparam logic signed [127:0] SUM_MIN = -128'sd2147483648;

    logic signed [VAL_W-1:0] accum_mat   [CELLS];
    logic signed [VAL_W-1:0] operand_mat [CELLS];
    t_elem                   expected_elems [$];
    int                      mismatch_cnt;

    function automatic void mac_element(input int r, input int c,
                                        output logic [VAL_W-1:0] v, output logic sat);
        logic signed [127:0] acc;
        logic signed [127:0] floored;
        int                  k;
        acc = '0;
        for (k = 0; k < DIM; k++)
            acc = acc + accum_mat[r*DIM+k] * operand_mat[k*DIM+c];
        floored = acc >>> FRAC_BITS;
        if (floored > SUM_MAX) begin
            v   = SAT_MAX;
            sat = 1'b1;
        end else if (floored < SUM_MIN) begin
            v   = SAT_MIN;
            sat = 1'b1;
        end else begin
            v   = floored[VAL_W-1:0];
            sat = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        int               i;
        int               idx;
        logic [VAL_W-1:0] fresh     [CELLS];
        logic             fresh_sat [CELLS];
        t_elem            got;
        t_elem            want;
        t_elem            elem;
        logic             bad;
        if (!i_rst_n) begin
            for (i = 0; i < CELLS; i++) begin
                accum_mat[i]   = '0;
                operand_mat[i] = '0;
            end
            expected_elems.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_res_ch.valid === 1'b1 && i_res_ch.ready === 1'b1) begin
                got = '{i_res_ch.out_row, i_res_ch.out_col, i_res_ch.out_value,
                        i_res_ch.saturated, i_res_ch.last};
                if (expected_elems.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result row %0d col %0d value %h sat %b last %b",
                                 $realtime, got.row, got.col, got.value, got.sat, got.last);
                end else begin
                    want = expected_elems.pop_front();
                    bad  = (got.row !== want.row) || (got.col !== want.col) ||
                           (got.value !== want.value) || (got.sat !== want.sat) ||
                           (got.last !== want.last);
                    if (bad) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $write("%0t: mismatch exp row %0d col %0d value %h sat %b last %b",
                                   $realtime, want.row, want.col, want.value, want.sat,
                                   want.last);
                            $display(" / got row %0d col %0d value %h sat %b last %b",
                                     got.row, got.col, got.value, got.sat, got.last);
                        end
                    end
                end
            end
            if (i_cmd_ch.valid === 1'b1 && i_cmd_ch.ready === 1'b1) begin
                idx = cell_addr(i_cmd_ch.row, i_cmd_ch.col);
                case (t_cmd'(i_cmd_ch.cmd))
                    CMD_WR_A: accum_mat[idx]   = i_cmd_ch.value;
                    CMD_WR_B: operand_mat[idx] = i_cmd_ch.value;
                    CMD_RD: begin
                        elem = '{i_cmd_ch.row, i_cmd_ch.col, accum_mat[idx], 1'b0, 1'b1};
                        expected_elems.push_back(elem);
                    end
                    default: begin
                        for (i = 0; i < CELLS; i++)
                            mac_element(i / DIM, i % DIM, fresh[i], fresh_sat[i]);
                        for (i = 0; i < CELLS; i++) begin
                            accum_mat[i] = fresh[i];
                            elem = '{FLD_W'(i / DIM), FLD_W'(i % DIM), fresh[i],
                                     fresh_sat[i], (i == CELLS - 1)};
                            expected_elems.push_back(elem);
                        end
                    end
                endcase
            end
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= expected_elems.size();
    end

endmodule

// File: tb/tb_matrix4_multiply_accumulate_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix4_multiply_accumulate_unit
// Drives element writes, reads and multiplies into the matrix unit with
// random gaps and output stalls, directed corner values first, a long output
// hold next and then random load-and-multiply sequences mixed with noise;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_matrix4_multiply_accumulate_unit;
    import mm4_pkg::*;

    localparam int N_RANDOM     = 440;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt;
    int   hold_req = 0;
    int   hold_ack = 0;
    bit   burst_mode = 1'b0;

    mm4_in_if  in_if ();
    mm4_out_if out_if ();

    matrix4_multiply_accumulate_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    mm4_result_checker i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_ch     (in_if),
        .i_res_ch     (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [FLD_W-1:0] rand_idx();
        return FLD_W'($urandom_range(0, DIM - 1));
    endfunction

    function automatic logic [VAL_W-1:0] small_q16();
        logic [VAL_W-1:0] raw;
        raw = $urandom;
        return VAL_W'($signed(raw) >>> 14);
    endfunction

    function automatic logic [VAL_W-1:0] q16_operand();
        logic [VAL_W-1:0] raw;
        logic [VAL_W-1:0] v;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = small_q16();
            5, 6:          v = raw;
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = SAT_MAX;
                    1:       v = SAT_MIN;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = 32'h0001_0000;
                endcase
            end
            default:       v = VAL_W'($signed(raw) >>> 7);
        endcase
        return v;
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [FLD_W-1:0] row,
                             input logic [FLD_W-1:0] col, input logic [VAL_W-1:0] value);
        int gap;
        gap = burst_mode ? 0 : gap_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd   <= cmd;
        in_if.row   <= row;
        in_if.col   <= col;
        in_if.value <= value;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // output side: random stalls, bursts with none, and a long hold on request
    initial begin : sink_side
        int run;
        int stall;
        out_if.ready <= 1'b0;
        forever begin
            if (hold_req != hold_ack) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_ack = hold_req;
            end else if (burst_mode) begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 16);
                out_if.ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                stall = gap_len();
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int i;
        int n;
        int kind;
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.cmd   <= CMD_WR_A;
        in_if.row   <= '0;
        in_if.col   <= '0;
        in_if.value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners: zero after reset, extreme values, both saturation directions
        send_item(CMD_RD,   2'd0, 2'd0, '0);
        send_item(CMD_RD,   2'd3, 2'd3, '1);
        send_item(CMD_WR_A, 2'd0, 2'd0, SAT_MAX);
        send_item(CMD_WR_A, 2'd3, 2'd3, SAT_MIN);
        send_item(CMD_WR_A, 2'd1, 2'd2, 32'h0001_0000);
        send_item(CMD_WR_A, 2'd2, 2'd1, 32'hFFFF_FFFF);
        send_item(CMD_WR_A, 2'd0, 2'd1, 32'h0002_0000);
        send_item(CMD_RD,   2'd0, 2'd0, '0);
        send_item(CMD_RD,   2'd3, 2'd3, '0);
        send_item(CMD_WR_B, 2'd0, 2'd0, SAT_MAX);
        send_item(CMD_WR_B, 2'd3, 2'd3, SAT_MAX);
        send_item(CMD_WR_B, 2'd0, 2'd3, 32'hFFFF_FFFF);
        send_item(CMD_WR_B, 2'd2, 2'd2, 32'h0001_0000);
        send_item(CMD_WR_B, 2'd1, 2'd1, 32'h0000_8000);
        send_item(CMD_WR_B, 2'd1, 2'd0, 32'hFFFF_0000);
        send_item(CMD_MUL,  2'd0, 2'd0, '0);
        send_item(CMD_RD,   2'd0, 2'd3, '0);
        send_item(CMD_MUL,  2'd3, 2'd3, '1);
        send_item(CMD_RD,   2'd0, 2'd0, '0);
        send_item(CMD_WR_A, 2'd0, 2'd0, 32'h0001_0000);
        send_item(CMD_WR_B, 2'd0, 2'd1, SAT_MIN);
        send_item(CMD_MUL,  2'd1, 2'd2, '0);
        send_item(CMD_RD,   2'd0, 2'd1, '0);
        wait_drained();

        // long output hold while commands keep coming
        burst_mode = 1'b1;
        hold_req++;
        send_item(CMD_MUL, 2'd0, 2'd0, '0);
        for (i = 0; i < 8; i++)
            send_item(CMD_RD, rand_idx(), rand_idx(), '0);
        burst_mode = 1'b0;
        wait_drained();

        sent = 0;
        while (sent < N_RANDOM) begin
            burst_mode = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 1) begin
                for (i = 0; i < CELLS; i++)
                    send_item(CMD_WR_A, FLD_W'(i / DIM), FLD_W'(i % DIM), small_q16());
                for (i = 0; i < CELLS; i++)
                    send_item(CMD_WR_B, FLD_W'(i / DIM), FLD_W'(i % DIM), small_q16());
                send_item(CMD_MUL, rand_idx(), rand_idx(), $urandom);
                sent += 2 * CELLS + 1;
            end else if (kind <= 7) begin
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++)
                    send_item($urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A,
                              rand_idx(), rand_idx(), q16_operand());
                send_item(CMD_MUL, rand_idx(), rand_idx(), $urandom);
                sent += n + 1;
            end else begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    send_item(t_cmd'($urandom_range(0, 3)), rand_idx(), rand_idx(), $urandom);
                sent += n;
            end
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
                send_item(CMD_RD, rand_idx(), rand_idx(), $urandom);
            sent += n;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        burst_mode = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
